@@ rtl/hsvrgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

  localparam int FRAC_BITS_DEF = 14;

  // Hue is in degrees times 64: a full turn is 23040, a sector 3840 = 15 << 8.
  localparam int HUE_SECTOR   = 3840;
  localparam int SECTOR_SHIFT = 8;
  localparam int SECTOR_DIV   = 15;
  localparam int NUM_SECTORS  = 6;
  localparam logic signed [16:0] HUE_FULL_S  = 17'sd23040;
  localparam logic signed [16:0] HUE_TWICE_S = 17'sd46080;

  localparam int HUE_W = 15;
  localparam int REM_W = 12;
  localparam int QUO_W = 8;
  localparam int RES_W = 4;

  // floor(x / 15) for x < 3840 as (x * 69906) >> 20
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP15 = 17'd69906;
  localparam int RECIP15_SHIFT = 20;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_FLAT,
    KIND_HUE
  } kind_t;

  typedef enum logic [2:0] {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } sector_t;

  typedef struct packed {
    logic signed [15:0] hue;
    logic signed [15:0] saturation;
    logic signed [15:0] value;
  } hsv_word_t;

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
  } rgb_word_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    kind_t              kind;
    sector_t            sec;
    logic [REM_W-1:0]   rem;
    logic [15:0]        flat;
  } cls_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

@@ rtl/hsvrgb_front.sv @@
// Front stage: accepts HSV words, wraps hue, finds the sector and clamps.
module hsvrgb_front #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsvrgb_pkg::hsv_word_t in_word,
  input  hsvrgb_pkg::q_stat_t   q_stat,
  output logic                  push,
  output hsvrgb_pkg::cls_t      cls,
  output logic [FRAC_BITS:0]    su,
  output logic [FRAC_BITS:0]    vu
);
  import hsvrgb_pkg::*;

  localparam int CLAMP_W = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;

  logic               front_valid_r, front_valid_nxt;
  cls_t               cls_r, cls_nxt;
  logic [FRAC_BITS:0] su_r, su_nxt, vu_r, vu_nxt;
  logic               accept;
  logic signed [16:0] hs, hw;
  logic [HUE_W-1:0]   hu, base;
  logic [2:0]         sec_idx;
  logic [CLAMP_W-1:0] s_ext, v_ext, one_c;

  assign in_stall = front_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = front_valid_r && !q_stat.full;
  assign cls      = cls_r;
  assign su       = su_r;
  assign vu       = vu_r;

  always_comb begin
    // wrap hue into one turn, upward or downward
    hs = {in_word.hue[15], in_word.hue};
    if (hs >= HUE_FULL_S) begin
      hw = hs - HUE_FULL_S;
    end else if (!hs[16]) begin
      hw = hs;
    end else if (hs >= -HUE_FULL_S) begin
      hw = hs + HUE_FULL_S;
    end else begin
      hw = hs + HUE_TWICE_S;
    end
    hu = hw[HUE_W-1:0];

    sec_idx = '0;
    base    = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hu >= HUE_W'(k * HUE_SECTOR)) begin
        sec_idx = 3'(k);
        base    = HUE_W'(k * HUE_SECTOR);
      end
    end

    s_ext = CLAMP_W'(in_word.saturation[14:0]);
    v_ext = CLAMP_W'(in_word.value[14:0]);
    one_c = CLAMP_W'(1) << FRAC_BITS;
    su_nxt = (s_ext > one_c) ? one_c[FRAC_BITS:0] : s_ext[FRAC_BITS:0];
    vu_nxt = (v_ext > one_c) ? one_c[FRAC_BITS:0] : v_ext[FRAC_BITS:0];

    cls_nxt.sec  = sector_t'(sec_idx);
    cls_nxt.rem  = REM_W'(hu - base);
    cls_nxt.kind = (in_word.saturation[15] || in_word.value[15]) ? KIND_FLAT : KIND_HUE;
    cls_nxt.flat = in_word.saturation[15] ? in_word.value : 16'd0;

    front_valid_nxt = front_valid_r;
    if (accept) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= cls_nxt;
      su_r  <= su_nxt;
      vu_r  <= vu_nxt;
    end
  end

endmodule

@@ rtl/hsvrgb_queue.sv @@
// Short word queue between the front and back stages.
module hsvrgb_queue #(
  parameter int DATA_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [DATA_W-1:0]   push_data,
  input  logic                pop,
  output logic [DATA_W-1:0]   pop_data,
  output hsvrgb_pkg::q_stat_t stat
);
  import hsvrgb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.avail = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/hsvrgb_back.sv @@
// Back pipeline: fraction, p, q and t, channel order and output register.
module hsvrgb_back #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hsvrgb_pkg::q_stat_t   q_stat,
  input  hsvrgb_pkg::cls_t      q_cls,
  input  logic [FRAC_BITS:0]    q_su,
  input  logic [FRAC_BITS:0]    q_vu,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsvrgb_pkg::rgb_word_t out_word
);
  import hsvrgb_pkg::*;

  localparam int W        = FRAC_BITS + 1;
  localparam int PW       = 2 * W;
  localparam int PQ_W     = REM_W + RECIP_W;
  localparam int SUB_SHIFT = FRAC_BITS - SECTOR_SHIFT;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS-1:0] frac_tab [2**RES_W];

  // fraction of a fifteenth, scaled to the sub-sector weight
  for (genvar i = 0; i < 2**RES_W; i++) begin : g_frac_tab
    localparam int TAB_VAL = (i << SUB_SHIFT) / SECTOR_DIV;
    assign frac_tab[i] = FRAC_BITS'(TAB_VAL);
  end

  logic                 v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic                 ld1, ld2, ld3, ld4, ld_out;
  cls_t                 cls1_r, cls2_r, cls3_r, cls4_r;
  logic [W-1:0]         su1_r, su2_r, vu1_r, vu2_r, vu3_r, vu4_r;
  logic [W-1:0]         p1_r, p2_r, p3_r, p4_r;
  logic [QUO_W-1:0]     quo1_r;
  logic [FRAC_BITS-1:0] frac2_r;
  logic [W-1:0]         sf3_r, sof3_r, q4_r, t4_r;
  rgb_word_t            out_word_r, out_word_nxt;

  logic [PQ_W-1:0]      quo_prod;
  logic [PW-1:0]        p_prod, sf_prod, sof_prod, q_prod, t_prod;
  logic [RES_W-1:0]     res15;
  logic [REM_W-1:0]     quo_x15;
  logic [15:0]          vv, pp, qq, tt;

  assign ld_out    = !out_valid_r || !out_stall;
  assign ld4       = !v4_r || ld_out;
  assign ld3       = !v3_r || ld4;
  assign ld2       = !v2_r || ld3;
  assign ld1       = !v1_r || ld2;
  assign q_pop     = q_stat.avail && ld1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    quo_prod = PQ_W'(q_cls.rem) * PQ_W'(RECIP15);
    p_prod   = PW'(q_vu) * PW'(ONE - q_su);

    quo_x15  = (REM_W'(quo1_r) << 4) - REM_W'(quo1_r);
    res15    = RES_W'(cls1_r.rem - quo_x15);

    sf_prod  = PW'(su2_r) * PW'(frac2_r);
    sof_prod = PW'(su2_r) * PW'(ONE - W'(frac2_r));

    q_prod   = PW'(vu3_r) * PW'(ONE - sf3_r);
    t_prod   = PW'(vu3_r) * PW'(ONE - sof3_r);

    vv = 16'(vu4_r);
    pp = 16'(p4_r);
    qq = 16'(q4_r);
    tt = 16'(t4_r);
    if (cls4_r.kind == KIND_FLAT) begin
      out_word_nxt = '{cls4_r.flat, cls4_r.flat, cls4_r.flat};
    end else begin
      case (cls4_r.sec)
        SEC_RED:     out_word_nxt = '{vv, tt, pp};
        SEC_YELLOW:  out_word_nxt = '{qq, vv, pp};
        SEC_GREEN:   out_word_nxt = '{pp, vv, tt};
        SEC_CYAN:    out_word_nxt = '{pp, qq, vv};
        SEC_BLUE:    out_word_nxt = '{tt, pp, vv};
        default:     out_word_nxt = '{vv, pp, qq};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= q_stat.avail;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (ld_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      cls1_r <= q_cls;
      su1_r  <= q_su;
      vu1_r  <= q_vu;
      quo1_r <= quo_prod[RECIP15_SHIFT +: QUO_W];
      p1_r   <= p_prod[FRAC_BITS +: W];
    end
    if (ld2) begin
      cls2_r  <= cls1_r;
      su2_r   <= su1_r;
      vu2_r   <= vu1_r;
      p2_r    <= p1_r;
      frac2_r <= (FRAC_BITS'(quo1_r) << SUB_SHIFT) + frac_tab[res15];
    end
    if (ld3) begin
      cls3_r <= cls2_r;
      vu3_r  <= vu2_r;
      p3_r   <= p2_r;
      sf3_r  <= sf_prod[FRAC_BITS +: W];
      sof3_r <= sof_prod[FRAC_BITS +: W];
    end
    if (ld4) begin
      cls4_r <= cls3_r;
      vu4_r  <= vu3_r;
      p4_r   <= p3_r;
      q4_r   <= q_prod[FRAC_BITS +: W];
      t4_r   <= t_prod[FRAC_BITS +: W];
    end
    if (ld_out) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: front, queue and back pipeline.
//
//   Port group   Direction  Word          Handshake
//   in_          input      hsv_word_t    in_valid / in_stall
//   out_         output     rgb_word_t    out_valid / out_stall
//
// One word per clock is sustained while nothing stalls; an accepted word
// passes through the front register, the queue, four back stages and the
// output register, the depth being set by the chain of dependent
// multiplies for q and t.
// Reset clears only the valid bits and the queue count and pointers.
// in_stall rises only when the front holds a word and the two-entry queue is
// full; out_stall holds the back pipeline, whose bubbles close up as it drains.
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsvrgb_pkg::hsv_word_t in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsvrgb_pkg::rgb_word_t out_word
);
  import hsvrgb_pkg::*;

  localparam int W      = FRAC_BITS + 1;
  localparam int DATA_W = $bits(cls_t) + 2 * W;

  // front to queue
  logic          q_push;
  cls_t          f_cls;
  logic [W-1:0]  f_su, f_vu;

  // queue to back
  q_stat_t       q_stat;
  logic          q_pop;
  logic [DATA_W-1:0] q_data;
  cls_t          b_cls;
  logic [W-1:0]  b_su, b_vu;

  // wrap hue, classify grey and black words, clamp saturation and value
  hsvrgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .q_stat  (q_stat),
    .push    (q_push),
    .cls     (f_cls),
    .su      (f_su),
    .vu      (f_vu)
  );

  // decouple the front from stalls on the result side
  hsvrgb_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_cls, f_su, f_vu}),
    .pop      (q_pop),
    .pop_data (q_data),
    .stat     (q_stat)
  );

  assign {b_cls, b_su, b_vu} = q_data;

  // fraction, p, q, t and channel order
  hsvrgb_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_cls    (b_cls),
    .q_su     (b_su),
    .q_vu     (b_vu),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // reset empties both sides
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output or front not empty after reset");

  // a full queue with no pop must stay full: the front never pushes into it
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("queue lost a word while full");

  // the back only pops a queue that holds a word
  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.avail)
    else $error("queue popped while empty");

endmodule
